>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// constants, types and helpers shared by the xxh32 controller and datapath
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;
  localparam logic [31:0] PRIME12 = PRIME1 + PRIME2;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_L_MUL,
    ST_L_ADD,
    ST_L_MUL2,
    ST_L_WB,
    ST_F_BASE,
    ST_F_ADD2,
    ST_F_ADD3,
    ST_F_LEN,
    ST_W_MUL,
    ST_W_ADD,
    ST_W_MUL2,
    ST_W_WB,
    ST_B_MUL,
    ST_B_ADD,
    ST_B_MUL2,
    ST_B_WB,
    ST_A_X15,
    ST_A_M2,
    ST_A_X13,
    ST_A_M3,
    ST_A_OUT
  } xxh_state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_TAKE,
    DP_LOAD,
    DP_MUL_LIN,
    DP_LANE_ADD,
    DP_MUL_LACC,
    DP_LANE_WB,
    DP_H_MERGE,
    DP_H_SEED,
    DP_H_ADD2,
    DP_H_ADD3,
    DP_H_LEN,
    DP_MUL_WORD,
    DP_H_MIXW,
    DP_MUL_H4,
    DP_H_WB,
    DP_MUL_BYTE,
    DP_H_MIXB,
    DP_MUL_H1,
    DP_H_X15,
    DP_MUL_H2,
    DP_H_X13,
    DP_MUL_H3,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // byte counts above four act as a full word
  function automatic logic [2:0] sat_count(input logic [2:0] c);
    return (c > FULL_BYTES) ? FULL_BYTES : c;
  endfunction

endpackage

>>> rtl/xxh_dp.sv
// ----------------------------------------------------------------------------
// xxh_dp
// xxh32 datapath: stripe buffer, lanes, hash accumulator, one shared multiplier
// ----------------------------------------------------------------------------
module xxh_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic [31:0]      in_data_word,
  input  logic [2:0]       in_byte_count,
  input  logic             in_last,
  input  xxh_pkg::dp_cmd_t cmd,
  output logic [31:0]      out_hash_value
);
  import xxh_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] len_r;
  logic [31:0] buf_r [4];
  logic [31:0] acc_r [4];
  logic [31:0] w_r;
  logic [31:0] h_r;
  logic [31:0] p_r;
  logic [31:0] hash_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [2:0]  take_cnt;
  logic        take_full;

  assign take_cnt  = in_last ? sat_count(in_byte_count) : FULL_BYTES;
  assign take_full = (take_cnt == FULL_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.op == DP_TAKE) begin
      len_r <= len_r + 32'(take_cnt);
    end else if (cmd.op == DP_H_LEN) begin
      len_r <= '0;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_MUL_LIN: begin
        mul_a = buf_r[cmd.idx];
        mul_b = PRIME2;
      end
      DP_MUL_LACC: begin
        mul_a = acc_r[cmd.idx];
        mul_b = PRIME1;
      end
      DP_MUL_WORD: begin
        mul_a = buf_r[cmd.idx];
        mul_b = PRIME3;
      end
      DP_MUL_H4: begin
        mul_a = h_r;
        mul_b = PRIME4;
      end
      DP_MUL_BYTE: begin
        mul_a = {24'd0, w_r[{cmd.idx, 3'b000} +: 8]};
        mul_b = PRIME5;
      end
      DP_MUL_H1: begin
        mul_a = h_r;
        mul_b = PRIME1;
      end
      DP_MUL_H2: begin
        mul_a = h_r;
        mul_b = PRIME2;
      end
      DP_MUL_H3: begin
        mul_a = h_r;
        mul_b = PRIME3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_TAKE: begin
        w_r <= in_data_word;
        if (take_full) begin
          buf_r[cmd.idx] <= in_data_word;
        end
      end
      DP_LOAD: begin
        acc_r[0] <= seed_r + PRIME12;
        acc_r[1] <= seed_r + PRIME2;
        acc_r[2] <= seed_r;
        acc_r[3] <= seed_r - PRIME1;
      end
      DP_LANE_ADD: acc_r[cmd.idx] <= rotl32(acc_r[cmd.idx] + p_r, 13);
      DP_LANE_WB:  acc_r[cmd.idx] <= p_r;
      DP_H_MERGE:  h_r <= rotl32(acc_r[0], 1) + rotl32(acc_r[1], 7);
      DP_H_SEED:   h_r <= seed_r + PRIME5;
      DP_H_ADD2:   h_r <= h_r + rotl32(acc_r[2], 12);
      DP_H_ADD3:   h_r <= h_r + rotl32(acc_r[3], 18);
      DP_H_LEN:    h_r <= h_r + len_r;
      DP_H_MIXW:   h_r <= rotl32(h_r + p_r, 17);
      DP_H_MIXB:   h_r <= rotl32(h_r + p_r, 11);
      DP_H_WB:     h_r <= p_r;
      DP_H_X15:    h_r <= h_r ^ (h_r >> 15);
      DP_H_X13:    h_r <= p_r ^ (p_r >> 13);
      DP_OUT:      hash_r <= p_r ^ (p_r >> 16);
      DP_MUL_LIN, DP_MUL_LACC, DP_MUL_WORD, DP_MUL_H4,
      DP_MUL_BYTE, DP_MUL_H1, DP_MUL_H2, DP_MUL_H3: p_r <= prod;
      default: ;
    endcase
  end

  assign out_hash_value = hash_r;

endmodule

>>> rtl/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// xxh32 sequencer: word counting, stripe rounds, finalization and result handoff
// ----------------------------------------------------------------------------
module xxh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_byte_count,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output xxh_pkg::dp_cmd_t  cmd
);
  import xxh_pkg::*;

  xxh_state_t state_r, state_nxt;
  logic [1:0] bw_r, bw_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       seen_r, seen_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] sat;
  logic       full;
  logic       out_free;

  assign sat      = sat_count(in_byte_count);
  assign full     = !in_last || (sat == FULL_BYTES);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bw_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      seen_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bw_r        <= bw_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      seen_r      <= seen_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    bw_nxt        = bw_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          cnt_nxt  = full ? 2'd0 : sat[1:0];
          idx_nxt  = '0;
          if (full && (bw_r == 2'd3)) begin
            bw_nxt    = '0;
            state_nxt = seen_r ? ST_L_MUL : ST_LOAD;
          end else begin
            if (full) begin
              bw_nxt = bw_r + 2'd1;
            end
            if (in_last) begin
              state_nxt = ST_F_BASE;
            end
          end
        end
      end
      ST_LOAD: begin
        seen_nxt  = 1'b1;
        state_nxt = ST_L_MUL;
      end
      ST_L_MUL:  state_nxt = ST_L_ADD;
      ST_L_ADD:  state_nxt = ST_L_MUL2;
      ST_L_MUL2: state_nxt = ST_L_WB;
      ST_L_WB: begin
        if (idx_r == 2'd3) begin
          idx_nxt   = '0;
          state_nxt = last_r ? ST_F_BASE : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_L_MUL;
        end
      end
      ST_F_BASE: state_nxt = seen_r ? ST_F_ADD2 : ST_F_LEN;
      ST_F_ADD2: state_nxt = ST_F_ADD3;
      ST_F_ADD3: state_nxt = ST_F_LEN;
      ST_F_LEN: begin
        idx_nxt = '0;
        if (bw_r != 2'd0) begin
          state_nxt = ST_W_MUL;
        end else if (cnt_r != 2'd0) begin
          state_nxt = ST_B_MUL;
        end else begin
          state_nxt = ST_A_X15;
        end
      end
      ST_W_MUL:  state_nxt = ST_W_ADD;
      ST_W_ADD:  state_nxt = ST_W_MUL2;
      ST_W_MUL2: state_nxt = ST_W_WB;
      ST_W_WB: begin
        if (idx_r == (bw_r - 2'd1)) begin
          idx_nxt   = '0;
          state_nxt = (cnt_r != 2'd0) ? ST_B_MUL : ST_A_X15;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_W_MUL;
        end
      end
      ST_B_MUL:  state_nxt = ST_B_ADD;
      ST_B_ADD:  state_nxt = ST_B_MUL2;
      ST_B_MUL2: state_nxt = ST_B_WB;
      ST_B_WB: begin
        if (idx_r == (cnt_r - 2'd1)) begin
          idx_nxt   = '0;
          state_nxt = ST_A_X15;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_B_MUL;
        end
      end
      ST_A_X15: state_nxt = ST_A_M2;
      ST_A_M2:  state_nxt = ST_A_X13;
      ST_A_X13: state_nxt = ST_A_M3;
      ST_A_M3:  state_nxt = ST_A_OUT;
      ST_A_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          bw_nxt        = '0;
          seen_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.op   = DP_NOP;
    cmd.idx  = idx_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.idx  = bw_r;
        if (in_valid) begin
          cmd.op = DP_TAKE;
        end
      end
      ST_LOAD:   cmd.op = DP_LOAD;
      ST_L_MUL:  cmd.op = DP_MUL_LIN;
      ST_L_ADD:  cmd.op = DP_LANE_ADD;
      ST_L_MUL2: cmd.op = DP_MUL_LACC;
      ST_L_WB:   cmd.op = DP_LANE_WB;
      ST_F_BASE: cmd.op = seen_r ? DP_H_MERGE : DP_H_SEED;
      ST_F_ADD2: cmd.op = DP_H_ADD2;
      ST_F_ADD3: cmd.op = DP_H_ADD3;
      ST_F_LEN:  cmd.op = DP_H_LEN;
      ST_W_MUL:  cmd.op = DP_MUL_WORD;
      ST_W_ADD:  cmd.op = DP_H_MIXW;
      ST_W_MUL2: cmd.op = DP_MUL_H4;
      ST_W_WB:   cmd.op = DP_H_WB;
      ST_B_MUL:  cmd.op = DP_MUL_BYTE;
      ST_B_ADD:  cmd.op = DP_H_MIXB;
      ST_B_MUL2: cmd.op = DP_MUL_H1;
      ST_B_WB:   cmd.op = DP_H_WB;
      ST_A_X15:  cmd.op = DP_H_X15;
      ST_A_M2:   cmd.op = DP_MUL_H2;
      ST_A_X13:  cmd.op = DP_H_X13;
      ST_A_M3:   cmd.op = DP_MUL_H3;
      ST_A_OUT:  cmd.op = out_free ? DP_OUT : DP_NOP;
      default:   cmd.op = DP_NOP;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/xxhash32_stream.sv
// ----------------------------------------------------------------------------
// xxhash32_stream
// streaming 32-bit xxhash of little-endian words with a programmable seed
// ----------------------------------------------------------------------------
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  input    | in_valid/in_ready, in_data_word, in_byte_count,| in
//           | in_last                                        |
//  result   | out_valid/out_ready, out_hash_value            | out
//  config   | cfg_wr_en, cfg_wr_data (seed)                  | in
//
//  a word that does not close a stripe is only buffered; one that closes a stripe
//  runs each lane through the shared multiplier (multiply, add, multiply, write
//  back), and on the first stripe of a message also loads the lanes from the seed
//  the last word then merges the seed or the lanes, adds the length, mixes each
//  leftover word and trailing byte and runs the avalanche before the result
//  the result sits in an output register; a new message is taken while it
//  waits, and only the next result stalls until it is taken
//  rst_n is synchronous, active low; the seed resets to zero
// ----------------------------------------------------------------------------
module xxhash32_stream (
  input  logic        clk,
  input  logic        rst_n,
  // seed register
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // word requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  // hash results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);
  import xxh_pkg::*;

  // one command per cycle from the sequencer to the datapath
  dp_cmd_t cmd;

  // sequencer: counts buffered words and steps the rounds and finalization
  xxh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // datapath: seed, length, stripe buffer, lanes, hash and output register
  xxh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last        (in_last),
    .cmd            (cmd),
    .out_hash_value (out_hash_value)
  );

endmodule

>>> rtl/xxh_chk.sv
// ----------------------------------------------------------------------------
// xxh_chk
// port-level checks for xxhash32_stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xxh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash_value
);

  // a stalled result holds its value
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hash_value))

  // a non-final word never brings a result in the next cycle
  `ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !in_last, !$rose(out_valid))

  // finalization always takes cycles after the last word
  `ASSERT_NEXT(a_final_busy, in_valid && in_ready && in_last, !in_ready)

  // a result is launched only from a busy cycle
  `ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind xxhash32_stream xxh_chk u_chk (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives word requests into xxhash32_stream with random gaps and seed changes
// between message groups, predicts each message hash in a local xxh32 model
// and compares every returned hash against the oldest pending prediction
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // xxh32 primes, kept local so the check does not lean on the design package
  localparam logic [31:0] K1 = 32'd2654435761;
  localparam logic [31:0] K2 = 32'd2246822519;
  localparam logic [31:0] K3 = 32'd3266489917;
  localparam logic [31:0] K4 = 32'd668265263;
  localparam logic [31:0] K5 = 32'd374761393;

  // xxh32 of the empty message and of "abc", both with seed 0
  localparam logic [31:0] HASH_EMPTY = 32'h02CC5D05;
  localparam logic [31:0] HASH_ABC   = 32'h32D153FF;

  localparam int RESET_CYCLES   = 11;
  localparam int ITEM_TOTAL     = 1750;
  localparam int NUM_PHASES     = 7;
  localparam int PRESSURE_PHASE = 2;
  localparam int HOLD_CYCLES    = 600;
  // margin after the last pending hash, so this covers any work in flight
  localparam int SETTLE_CYCLES  = 80;
  localparam int STALL_LIMIT    = 4000;
  localparam int NUM_DIRECTED   = 25;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic        known;
    logic [31:0] hash;
  } word_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_hash_value;

  // side info that travels with the current request: a hash typed into the table
  logic        row_known = 1'b0;
  logic [31:0] row_hash = '0;

  // idle controls shared between the sender, the receiver and the phase sequencer
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_armed = 1'b0;

  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  logic [31:0] pending_hashes [$];

  // local hash state: seed register copy, lanes, stripe words, length, stripe flag
  logic [31:0] seed_copy;
  logic [31:0] lanes [4];
  logic [31:0] stripe_words [4];
  int unsigned held_words;
  logic [31:0] byte_total;
  bit          stripe_done;

  word_row_t   directed_rows [NUM_DIRECTED];

  xxhash32_stream i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // rotate left by taking the top half of the doubled word after a shift
  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
    logic [63:0] dbl;
    dbl = {x, x} << r;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] lane_mix(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] a;
    a = acc + w * K2;
    return rol(a, 13) * K1;
  endfunction

  // push a full word into the stripe; a completed stripe runs all four lanes
  function automatic void stripe_take(input logic [31:0] w);
    int k;
    stripe_words[held_words] = w;
    held_words++;
    if (held_words == 4) begin
      // lanes start from whatever seed is current when the first stripe closes
      if (!stripe_done) begin
        lanes[0] = seed_copy + K1 + K2;
        lanes[1] = seed_copy + K2;
        lanes[2] = seed_copy;
        lanes[3] = seed_copy - K1;
        stripe_done = 1'b1;
      end
      for (k = 0; k < 4; k++)
        lanes[k] = lane_mix(lanes[k], stripe_words[k]);
      held_words = 0;
    end
  endfunction

  // advance the hash state by one accepted word; returns 1 with the hash on a last word
  function automatic bit hash_step(input logic [31:0] w, input logic [2:0] cnt,
                                   input logic lst, output logic [31:0] h);
    int unsigned tail;
    int k;
    h = '0;
    if (!lst) begin
      // non-last words always count as four bytes
      byte_total += 32'd4;
      stripe_take(w);
      return 1'b0;
    end
    // byte counts above four saturate
    tail = (cnt > 3'd4) ? 4 : cnt;
    byte_total += tail;
    if (tail == 4) begin
      stripe_take(w);
      tail = 0;
    end
    if (stripe_done)
      h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
    else
      h = seed_copy + K5;
    h += byte_total;
    for (k = 0; k < held_words; k++) begin
      h += stripe_words[k] * K3;
      h = rol(h, 17) * K4;
    end
    for (k = 0; k < tail; k++) begin
      h += {24'd0, w[8*k +: 8]} * K5;
      h = rol(h, 11) * K1;
    end
    // avalanche
    h ^= h >> 15;
    h *= K2;
    h ^= h >> 13;
    h *= K3;
    h ^= h >> 16;
    held_words = 0;
    byte_total = '0;
    stripe_done = 1'b0;
    return 1'b1;
  endfunction

  // observe both channels and the seed port at the rising edge
  always @(posedge clk) begin : observe
    logic [31:0] predicted;
    logic [31:0] wanted;
    if (!rst_n) begin
      seed_copy = '0;
      held_words = 0;
      byte_total = '0;
      stripe_done = 1'b0;
      pending_hashes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          $error("hash_value: no hash pending, got %h", out_hash_value);
          fail_count++;
        end else begin
          wanted = pending_hashes.pop_front();
          if (out_hash_value !== wanted) begin
            $error("hash_value mismatch: expected %h, got %h", wanted, out_hash_value);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en)
        seed_copy = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (hash_step(in_data_word, in_byte_count, in_last, predicted))
          pending_hashes.push_back(row_known ? row_hash : predicted);
      end
    end
  end

  // result side: random stall bursts, plus one long hold when the sequencer asks
  initial begin : receiver
    int unsigned burst;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        burst = $urandom_range(1, 11);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // end the run if neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // offer one word request, called and returning at a falling edge
  task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                           input logic lst, input logic known, input logic [31:0] hash);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_word = word;
    in_byte_count = count;
    in_last = lst;
    row_known = known;
    row_hash = hash;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    @(negedge clk);
  endtask

  // message words: mostly random, with all-zero and all-one words mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // one random message: mostly short, some spanning several stripes
  task automatic send_message();
    int unsigned n;
    int unsigned pick;
    int unsigned i;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      n = $urandom_range(1, 8);
    else if (pick < 9)
      n = $urandom_range(9, 20);
    else
      n = $urandom_range(21, 48);
    // byte_count on non-last words is noise the block must ignore
    for (i = 1; i < n; i++)
      send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
    send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
  endtask

  // wait until every predicted hash has come back, then let the block go quiet
  task automatic settle_block();
    while (pending_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int p;
    int unsigned phase_end;
    logic [31:0] seeds [NUM_PHASES];

    // word, byte_count, last, typed hash present, typed hash
    directed_rows = '{
      // empty message, and empty message with every data bit set
      '{32'h0000_0000, 3'd0, 1'b1, 1'b1, HASH_EMPTY},
      '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, HASH_EMPTY},
      // "abc"
      '{32'h0063_6261, 3'd3, 1'b1, 1'b1, HASH_ABC},
      // single-word messages, oversized counts saturate to four bytes
      '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, '0},
      '{32'h8000_0001, 3'd5, 1'b1, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b1, 1'b0, '0},
      '{32'h0000_00FF, 3'd1, 1'b1, 1'b0, '0},
      '{32'hFFFF_0000, 3'd2, 1'b1, 1'b0, '0},
      // exactly one stripe, closed by a full last word
      '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hAAAA_AAAA, 3'd3, 1'b0, 1'b0, '0},
      '{32'h5555_5555, 3'd4, 1'b1, 1'b0, '0},
      // one stripe, three leftover words and three tail bytes
      '{32'h0123_4567, 3'd6, 1'b0, 1'b0, '0},
      '{32'h89AB_CDEF, 3'd1, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd5, 1'b0, 1'b0, '0},
      '{32'h7654_3210, 3'd0, 1'b0, 1'b0, '0},
      '{32'hFEDC_BA98, 3'd4, 1'b0, 1'b0, '0},
      '{32'h1357_9BDF, 3'd7, 1'b0, 1'b0, '0},
      '{32'h2468_ACE0, 3'd3, 1'b1, 1'b0, '0},
      // one stripe then a last word with no bytes
      '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, '0}
    };
    // seed extremes first, random seeds and single-bit seeds later
    seeds = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h8000_0000,
              $urandom(), 32'h0000_0001, $urandom()};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed words run on the reset seed
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].count, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].hash);
    in_valid = 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      // seed changes only between messages, with the block drained
      settle_block();
      cfg_wr_data = seeds[p];
      cfg_wr_en = 1'b1;
      @(negedge clk);
      cfg_wr_en = 1'b0;
      // long result hold while words keep coming, so the input backs up
      if (p == PRESSURE_PHASE)
        hold_armed = 1'b1;
      // closing stretch runs at full rate on both sides
      if (p == NUM_PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      phase_end = NUM_DIRECTED + (ITEM_TOTAL - NUM_DIRECTED) * (p + 1) / NUM_PHASES;
      while (items_sent < phase_end)
        send_message();
      in_valid = 1'b0;
    end

    settle_block();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
